// ===== hw/rtl/bcps_pkg.sv =====
// Shared types, constants and defaults for the best-candidate point sampler.
package bcps_pkg;

	localparam int unsigned DEF_MAX_POINTS = 1024;
	localparam int unsigned DEF_MAX_ROUND  = 64;

	localparam int unsigned COORD_W  = 16;
	localparam int unsigned RED_W    = 8;
	localparam int unsigned TGT_W    = 11;
	localparam int unsigned RSIZE_W  = 7;
	localparam int unsigned RAD_W    = 8;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned SQ_W     = 2 * COORD_W;
	localparam int unsigned DIST_W   = SQ_W + 1;
	localparam int unsigned CFG_W    = TGT_W;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [RED_W-1:0]   RED_ACCEPT    = 8'hFF;
	localparam logic [TGT_W-1:0]   TARGET_RESET  = 11'd1024;
	localparam logic [RSIZE_W-1:0] RSIZE_RESET   = 7'd64;
	localparam logic [RAD_W-1:0]   RADIUS_RESET  = 8'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET = 2'd0,
		CFG_RSIZE  = 2'd1,
		CFG_RADIUS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic issue;  // a store read was issued this cycle
		logic clear;  // restart the nearest-distance search
	} dist_ctl_t;

	typedef struct packed {
		logic busy;   // reads still in flight
	} dist_sts_t;

endpackage

// ===== hw/rtl/bcps_cand_if.sv =====
// Candidate channel: one candidate point and its mask pixel.
interface bcps_cand_if import bcps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] cand_x;
	logic [COORD_W-1:0] cand_y;
	logic [RED_W-1:0]   pixel_red;

	modport source (output valid, cand_x, cand_y, pixel_red, input ready);
	modport sink   (input valid, cand_x, cand_y, pixel_red, output ready);
endinterface

// ===== hw/rtl/bcps_place_if.sv =====
// Placement channel: one newly placed point.
interface bcps_place_if import bcps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] placed_x;
	logic [COORD_W-1:0] placed_y;
	logic [RAD_W-1:0]   placed_radius;
	logic [INDEX_W-1:0] placed_index;
	logic               all_placed;

	modport source (output valid, placed_x, placed_y, placed_radius, placed_index,
		all_placed, input ready);
	modport sink   (input valid, placed_x, placed_y, placed_radius, placed_index,
		all_placed, output ready);
endinterface

// ===== hw/rtl/best_candidate_point_sampler.sv =====
// Best-candidate point sampler: sequencer, configuration, point store and output register.
//
// Candidates arrive on cand (valid/ready); placed points leave on place (valid/ready).
// Registers target_count, candidates_per_round and dot_radius are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is idle,
// which the block itself leaves unenforced. Unknown indexes are dropped. A candidate
// with pixel_red other than 255, or one that arrives after the target count is
// reached, is taken and gives nothing. The very first valid candidate goes straight
// to placement. Every later one walks the point store, one read per cycle through
// the distance pipeline (scan), waits for the pipeline to empty (drain) and updates
// the round's best (update); a round that ends in a placement then waits in place for
// a free output register. The last candidate of a round emits the farthest candidate
// of the round. cand.ready is high only while the sequencer is idle. A placed point
// sits in an output register; the next candidate is taken while it waits, and the
// sequencer holds a new placement until the register is free.
// Reset clears the counters, the round state and the output valid flag and loads the
// register defaults (1024, 64, 4). The point store has no reset: it is read only
// below the placed count.
module best_candidate_point_sampler import bcps_pkg::*; #(
	parameter int unsigned MAX_POINTS = DEF_MAX_POINTS,
	parameter int unsigned MAX_ROUND  = DEF_MAX_ROUND
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bcps_cand_if.sink            cand,
	bcps_place_if.source         place,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int unsigned AW     = $clog2(MAX_POINTS);
	localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int unsigned CMP_W  = (CNT_W > TGT_W) ? CNT_W : TGT_W;
	localparam int unsigned RW     = $clog2(MAX_ROUND + 1);
	localparam int unsigned RCMP_W = (RW > RSIZE_W) ? RW : RSIZE_W;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_UPDATE = 5'b01000,
		S_PLACE  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [TGT_W-1:0]     target_q;
	logic [RSIZE_W-1:0]   rsize_q;
	logic [RAD_W-1:0]     radius_q;
	logic [CNT_W-1:0]     total_q;
	logic [RW-1:0]        round_q;
	logic [DIST_W-1:0]    best_dist_q;
	point_t               best_pt_q;
	point_t               cand_q;
	point_t               place_pt_q;
	logic [AW-1:0]        rd_addr_q;

	logic                 out_v_q;
	point_t               out_pt_q;
	logic [RAD_W-1:0]     out_rad_q;
	logic [INDEX_W-1:0]   out_idx_q;
	logic                 out_all_q;

	logic [CMP_W-1:0]     eff_target;
	logic [CMP_W-1:0]     total_w;
	logic [CMP_W-1:0]     total_nx_w;
	logic [RCMP_W-1:0]    eff_round;
	logic [RCMP_W-1:0]    round_nx;
	logic                 accept;
	logic                 ignore_cand;
	logic                 scan_last;
	logic                 out_free;
	logic                 farther;
	point_t               win_pt;
	logic                 ram_we;
	point_t               ram_rdata;
	dist_ctl_t            dctl;
	dist_sts_t            dsts;
	logic [DIST_W-1:0]    min_dist;

	// effective register values after saturation
	always_comb begin
		eff_target = CMP_W'(target_q);
		if (eff_target > CMP_W'(MAX_POINTS)) begin
			eff_target = CMP_W'(MAX_POINTS);
		end
		eff_round = RCMP_W'(rsize_q);
		if (eff_round == '0) begin
			eff_round = RCMP_W'(1);
		end
		if (eff_round > RCMP_W'(MAX_ROUND)) begin
			eff_round = RCMP_W'(MAX_ROUND);
		end
	end

	assign total_w     = CMP_W'(total_q);
	assign total_nx_w  = total_w + CMP_W'(1);
	assign round_nx    = RCMP_W'(round_q) + RCMP_W'(1);
	assign accept      = cand.valid && cand.ready;
	assign ignore_cand = (total_w >= eff_target) || (cand.pixel_red != RED_ACCEPT);
	assign scan_last   = (CNT_W'(rd_addr_q) + CNT_W'(1)) == total_q;
	assign out_free    = !out_v_q || place.ready;
	assign farther     = min_dist > best_dist_q;
	assign win_pt      = farther ? cand_q : best_pt_q;
	assign ram_we      = (state_q == S_PLACE) && out_free;

	assign cand.ready = (state_q == S_IDLE);

	assign dctl.issue = (state_q == S_SCAN);
	assign dctl.clear = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			rsize_q  <= RSIZE_RESET;
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET: target_q <= cfg_data[TGT_W-1:0];
				CFG_RSIZE:  rsize_q  <= cfg_data[RSIZE_W-1:0];
				CFG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			round_q     <= '0;
			best_dist_q <= '0;
			best_pt_q   <= '0;
			rd_addr_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && !ignore_cand) begin
						if (total_q == '0) begin
							state_q <= S_PLACE;
						end else begin
							state_q <= S_SCAN;
						end
						rd_addr_q <= '0;
					end
				end
				S_SCAN: begin
					rd_addr_q <= rd_addr_q + AW'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!dsts.busy) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (farther) begin
						best_dist_q <= min_dist;
						best_pt_q   <= cand_q;
					end
					if (round_nx >= eff_round) begin
						state_q <= S_PLACE;
					end else begin
						round_q <= round_nx[RW-1:0];
						state_q <= S_IDLE;
					end
				end
				S_PLACE: begin
					if (out_free) begin
						total_q     <= total_q + CNT_W'(1);
						round_q     <= '0;
						best_dist_q <= '0;
						best_pt_q   <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q <= '{x: cand.cand_x, y: cand.cand_y};
		end
		if (state_q == S_IDLE && accept) begin
			place_pt_q <= '{x: cand.cand_x, y: cand.cand_y};
		end else if (state_q == S_UPDATE) begin
			place_pt_q <= win_pt;
		end
		if (ram_we) begin
			out_pt_q  <= place_pt_q;
			out_rad_q <= radius_q;
			out_idx_q <= total_w[INDEX_W-1:0];
			out_all_q <= (total_nx_w == eff_target);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ram_we) begin
			out_v_q <= 1'b1;
		end else if (place.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign place.valid         = out_v_q;
	assign place.placed_x      = out_pt_q.x;
	assign place.placed_y      = out_pt_q.y;
	assign place.placed_radius = out_rad_q;
	assign place.placed_index  = out_idx_q;
	assign place.all_placed    = out_all_q;

	bcps_ram #(
		.WIDTH ($bits(point_t)),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (total_q[AW-1:0]),
		.wdata (place_pt_q),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	bcps_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.cand     (cand_q),
		.stored   (ram_rdata),
		.min_dist (min_dist),
		.sts      (dsts)
	);

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> CNT_W'(rd_addr_q) < total_q)
		else $error("store read beyond placed points");

	a_update_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |-> !dsts.busy)
		else $error("distance pipeline busy at update");

	a_load_from_place: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_PLACE))
		else $error("placement shown outside place state");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_w <= CMP_W'(MAX_POINTS))
		else $error("placed count beyond store depth");

endmodule

// ===== hw/rtl/bcps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bcps_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/bcps_dist_unit.sv =====
// Pipelined squared-distance unit with running minimum over streamed store reads.
module bcps_dist_unit import bcps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dist_ctl_t         ctl,
	input  point_t            cand,
	input  point_t            stored,
	output logic [DIST_W-1:0] min_dist,
	output dist_sts_t         sts
);

	logic               v_s1, v_s2, v_s3;
	logic [COORD_W-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]    sqx_s3, sqy_s3;
	logic [DIST_W-1:0]  sum;
	logic [DIST_W-1:0]  min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= (cand.x > stored.x) ? cand.x - stored.x : stored.x - cand.x;
		dy_s2  <= (cand.y > stored.y) ? cand.y - stored.y : stored.y - cand.y;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
	end

	assign sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	// all ones is above any reachable distance, so the first read always wins
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			min_q <= '1;
		end else if (v_s3 && sum < min_q) begin
			min_q <= sum;
		end
	end

	assign min_dist = min_q;
	assign sts.busy = v_s1 | v_s2 | v_s3;

endmodule

// ===== tb/bcps_placement_checker.sv =====
// Placement checker: predicts every placed point from the candidate stream and compares.
module bcps_placement_checker import bcps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bcps_cand_if                 cand,
	bcps_place_if                place,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int unsigned          fail_count,
	output int unsigned          pending,
	output int unsigned          placed
);

	localparam int unsigned REPORT_CAP = 50;

	typedef struct packed {
		point_t             pt;
		logic [RAD_W-1:0]   radius;
		logic [INDEX_W-1:0] index;
		logic               done;
	} placement_t;

	logic [TGT_W-1:0]   target_reg;
	logic [RSIZE_W-1:0] rsize_reg;
	logic [RAD_W-1:0]   radius_reg;

	point_t            point_mem [DEF_MAX_POINTS];
	int unsigned       total;
	int unsigned       round_n;
	int unsigned       errors;
	logic [DIST_W-1:0] far_dist;
	point_t            far_pt;
	placement_t        placement_q [$];

	function automatic int unsigned target_limit();
		return (target_reg > DEF_MAX_POINTS) ? DEF_MAX_POINTS : int'(target_reg);
	endfunction

	// Store the point, queue the placement and open a fresh round.
	function automatic void place_point(input point_t pt);
		placement_t p;
		if (total < DEF_MAX_POINTS)
			point_mem[total] = pt;
		p.pt     = pt;
		p.radius = radius_reg;
		p.index  = INDEX_W'(total);
		p.done   = (total + 1 == target_limit());
		placement_q.insert(placement_q.size(), p);
		total    = total + 1;
		round_n  = 0;
		far_dist = '0;
		far_pt   = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict_and_check
		point_t             cand_pt;
		placement_t         seen;
		placement_t         want;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [SQ_W-1:0]    sqx;
		logic [SQ_W-1:0]    sqy;
		logic [DIST_W-1:0]  pair_dist;
		logic [DIST_W-1:0]  nearest;
		int unsigned        round_len;
		if (!arst_n) begin
			placement_q.delete();
			total      = 0;
			round_n    = 0;
			errors     = 0;
			far_dist   = '0;
			far_pt     = '0;
			target_reg = TARGET_RESET;
			rsize_reg  = RSIZE_RESET;
			radius_reg = RADIUS_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TARGET: target_reg = cfg_data[TGT_W-1:0];
					CFG_RSIZE:  rsize_reg  = cfg_data[RSIZE_W-1:0];
					CFG_RADIUS: radius_reg = cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end

			// a result can never leave on the edge that takes its own candidate
			if (place.valid && place.ready) begin
				seen = {place.placed_x, place.placed_y, place.placed_radius,
					place.placed_index, place.all_placed};
				if (placement_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: unexpected placement x=%h y=%h radius=%0d index=%0d all=%0b",
							$time, seen.pt.x, seen.pt.y, seen.radius, seen.index, seen.done);
				end else begin
					want = placement_q.pop_front();
					if (seen.pt.x !== want.pt.x || seen.pt.y !== want.pt.y ||
							seen.radius !== want.radius || seen.index !== want.index ||
							seen.done !== want.done) begin
						errors++;
						if (errors <= REPORT_CAP)
							$display("%0t: placement mismatch: expected x=%h y=%h radius=%0d index=%0d all=%0b, got x=%h y=%h radius=%0d index=%0d all=%0b",
								$time, want.pt.x, want.pt.y, want.radius, want.index, want.done,
								seen.pt.x, seen.pt.y, seen.radius, seen.index, seen.done);
					end
				end
			end

			if (cand.valid && cand.ready) begin
				cand_pt = {cand.cand_x, cand.cand_y};
				if (total < target_limit() && cand.pixel_red == RED_ACCEPT) begin
					if (total == 0) begin
						place_point(cand_pt);
					end else begin
						// all ones exceeds any real distance, so the first point always wins
						nearest = '1;
						for (int i = 0; i < total; i++) begin
							dx   = (cand_pt.x > point_mem[i].x) ? cand_pt.x - point_mem[i].x
								: point_mem[i].x - cand_pt.x;
							dy   = (cand_pt.y > point_mem[i].y) ? cand_pt.y - point_mem[i].y
								: point_mem[i].y - cand_pt.y;
							sqx  = SQ_W'(dx) * SQ_W'(dx);
							sqy  = SQ_W'(dy) * SQ_W'(dy);
							pair_dist = {1'b0, sqx} + {1'b0, sqy};
							if (pair_dist < nearest)
								nearest = pair_dist;
						end
						if (nearest > far_dist) begin
							far_dist = nearest;
							far_pt   = cand_pt;
						end
						round_len = (rsize_reg == 0) ? 1
							: (rsize_reg > DEF_MAX_ROUND) ? DEF_MAX_ROUND : int'(rsize_reg);
						round_n++;
						if (round_n >= round_len)
							place_point(far_pt);
					end
				end
			end
		end
		fail_count <= errors;
		pending    <= placement_q.size();
		placed     <= total;
	end

endmodule

// ===== tb/best_candidate_point_sampler_test.sv =====
// Testbench top: clock, reset, candidate stimulus, placement sink and verdict.
module best_candidate_point_sampler_test;
	import bcps_pkg::*;

	localparam int unsigned SETTLE_CYCLES = DEF_MAX_POINTS + 32;
	localparam int unsigned HOLD_CYCLES   = 2000;
	localparam int unsigned CYCLE_LIMIT   = 3000000;
	localparam int unsigned RANDOM_PHASES = 6;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 hold_req;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned placed;
	int unsigned cycles = 0;

	bcps_cand_if  cand_ch ();
	bcps_place_if place_ch ();

	best_candidate_point_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand      (cand_ch),
		.place     (place_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bcps_placement_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand       (cand_ch),
		.place      (place_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.placed     (placed)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Placement sink: random stalls, quiet stretches, and one long hold-off on request.
	int unsigned sink_wait;
	bit          sink_quiet;
	bit          hold_taken;

	always @(posedge clk) begin
		if (!arst_n) begin
			place_ch.ready <= 1'b0;
			sink_wait  = 0;
			sink_quiet = 1'b0;
			hold_taken = 1'b0;
		end else begin
			if ($urandom_range(0, 149) == 0)
				sink_quiet = ~sink_quiet;
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				sink_wait  = HOLD_CYCLES;
				place_ch.ready <= 1'b0;
			end else if (sink_wait != 0) begin
				sink_wait--;
				place_ch.ready <= 1'b0;
			end else begin
				place_ch.ready <= 1'b1;
				if (!sink_quiet)
					sink_wait = draw_gap();
			end
		end
	end

	task automatic offer_candidate(input point_t pt, input logic [RED_W-1:0] red,
			input int unsigned gap);
		if (gap != 0) begin
			cand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cand_ch.valid     <= 1'b1;
		cand_ch.cand_x    <= pt.x;
		cand_ch.cand_y    <= pt.y;
		cand_ch.pixel_red <= red;
		do @(posedge clk); while (!cand_ch.ready);
	endtask

	// Stop offering and wait until every predicted placement has been taken.
	task automatic drain();
		cand_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// The block may still be scoring a candidate that places nothing, so let it finish first.
	task automatic write_regs(input int unsigned target, input int unsigned rsize,
			input int unsigned radius);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TARGET;
		cfg_data  <= CFG_W'(target);
		@(posedge clk);
		cfg_index <= CFG_RSIZE;
		cfg_data  <= CFG_W'(rsize);
		@(posedge clk);
		cfg_index <= CFG_RADIUS;
		cfg_data  <= CFG_W'(radius);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		point_t             pt;
		point_t             recent [8];
		int unsigned        recent_wr;
		logic [RED_W-1:0]   red;
		int unsigned        target;
		int unsigned        rsize;
		int unsigned        radius;
		int unsigned        count;
		bit                 steady;

		cand_ch.valid     = 1'b0;
		cand_ch.cand_x    = '0;
		cand_ch.cand_y    = '0;
		cand_ch.pixel_red = '0;
		place_ch.ready    = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_TARGET;
		cfg_data          = '0;
		hold_req          = 1'b0;
		arst_n            = 1'b0;
		recent_wr         = 0;
		foreach (recent[i])
			recent[i] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// zero target: nothing is ever placed
		write_regs(0, 1, 255);
		offer_candidate({16'hFFFF, 16'hFFFF}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h0000, 16'h0000}, RED_ACCEPT, draw_gap());
		drain();

		// single target, round size zero acts as one; masked pixel first, then target reached
		write_regs(1, 0, 0);
		offer_candidate({16'h1234, 16'h5678}, 8'hFE, draw_gap());
		offer_candidate({16'hFFFF, 16'hFFFF}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h0000, 16'h0000}, RED_ACCEPT, draw_gap());
		drain();

		// oversized target saturates; a duplicate point has zero distance and yields the origin
		write_regs(2047, 1, 8'hA5);
		offer_candidate({16'h0000, 16'h0000}, RED_ACCEPT, draw_gap());
		offer_candidate({16'hFFFF, 16'hFFFF}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h0000, 16'h0000}, 8'h00, draw_gap());
		offer_candidate({16'h8000, 16'h8000}, RED_ACCEPT, draw_gap());
		drain();

		// rounds of three: equal distances, then a round of all zero distances
		write_regs(1024, 3, 8'h5A);
		offer_candidate({16'hFFFF, 16'h0000}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h0000, 16'hFFFF}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h4000, 16'h4000}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h0000, 16'h0000}, RED_ACCEPT, draw_gap());
		offer_candidate({16'hFFFF, 16'hFFFF}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h8000, 16'h8000}, RED_ACCEPT, draw_gap());
		drain();

		// round size lowered while a round is open
		write_regs(1024, 5, 1);
		offer_candidate({16'h0001, 16'h0002}, RED_ACCEPT, draw_gap());
		offer_candidate({16'h0003, 16'h0004}, RED_ACCEPT, draw_gap());
		drain();
		write_regs(1024, 2, 1);
		offer_candidate({16'h7FFF, 16'h0000}, RED_ACCEPT, draw_gap());
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			radius = $urandom_range(0, 255);
			case (ph)
				0: begin
					target = 48;
					rsize  = $urandom_range(1, 4);
					count  = 110;
				end
				1: begin
					target = 1024;
					rsize  = 1;
					count  = 80;
				end
				2: begin
					// target is met early; the remainder is ignored
					target = placed + 6;
					rsize  = $urandom_range(1, 2);
					count  = 30;
				end
				3: begin
					target = 1024;
					rsize  = 127;
					radius = 255;
					count  = 140;
				end
				4: begin
					target = $urandom_range(1025, 2047);
					rsize  = $urandom_range(2, 6);
					radius = 0;
					count  = 120;
				end
				default: begin
					target = 1024;
					rsize  = $urandom_range(1, 8);
					count  = 100;
				end
			endcase
			write_regs(target, rsize, radius);
			// single-candidate rounds with the sink held off fill the output register
			if (ph == 1)
				hold_req <= 1'b1;
			steady = ($urandom_range(0, 3) == 0);

			for (int n = 0; n < count; n++) begin
				if (ph == 4 && n == 60)
					drain();
				red = RED_ACCEPT;
				if ($urandom_range(0, 99) < 10)
					red = RED_W'($urandom_range(0, 254));
				case ($urandom_range(0, 9))
					0: pt = recent[$urandom_range(0, 7)];
					1: pt = {COORD_W'($urandom_range(0, 3)), COORD_W'($urandom_range(0, 3))};
					2: begin
						pt.x = ($urandom_range(0, 1) != 0) ? '1 : '0;
						pt.y = ($urandom_range(0, 1) != 0) ? '1 : '0;
					end
					default: pt = $urandom();
				endcase
				if (red == RED_ACCEPT) begin
					recent[recent_wr] = pt;
					recent_wr = (recent_wr + 1) % 8;
				end
				offer_candidate(pt, red, steady ? 0 : draw_gap());
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
